// ===== rtl/core/sorted_key_insert_table_top_assert.svh =====
// Assertion macros shared by the sorted key insert table modules.
// Depends on nothing; define NO_ASSERTIONS to compile them away.
`ifndef SORTED_KEY_INSERT_TABLE_TOP_ASSERT_SVH
`define SORTED_KEY_INSERT_TABLE_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define SKIT_ASSERT_NOW(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed: same-cycle implication");
// Next-cycle implication.
`define SKIT_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed: next-cycle implication");
`else
`define SKIT_ASSERT_NOW(label, clk, rst_n, pre, post)
`define SKIT_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// ===== rtl/core/skit_pkg.sv =====
// Types, codes and the key compare of the sorted key insert table.
// Used by the controller, the datapath and the top level; depends on nothing.
package skit_pkg;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_READ   = 1'b1;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	typedef struct packed {
		logic        action;
		logic [6:0]  day;
		logic [6:0]  hour;
		logic [6:0]  minute;
		logic [15:0] message_tag;
		logic [5:0]  position;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [6:0]  out_day;
		logic [6:0]  out_hour;
		logic [6:0]  out_minute;
		logic [15:0] out_tag;
		logic [6:0]  entry_count;
	} rsp_t;

	typedef struct packed {
		logic [6:0]  day;
		logic [6:0]  hour;
		logic [6:0]  minute;
		logic [15:0] tag;
	} entry_t;

	typedef enum logic [1:0] {
		RES_INSERT,
		RES_FULL,
		RES_RANGE,
		RES_READ
	} res_kind_t;

	typedef struct packed {
		logic      load;
		logic      rd_pos;
		logic      rd_prev;
		logic      wr_shift;
		logic      wr_fresh;
		logic      emit;
		res_kind_t kind;
	} cmd_t;

	typedef struct packed {
		logic is_read;
		logic full;
		logic range_err;
		logic at_zero;
		logic ge;
	} sts_t;

	// Key of a is greater than or equal to key of b, day first, then hour, then minute.
	function automatic logic key_ge(entry_t a, entry_t b);
		return {a.day, a.hour, a.minute} >= {b.day, b.hour, b.minute};
	endfunction

endpackage

// ===== rtl/core/skit_ctrl.sv =====
// Controller of the sorted key insert table: sequences reads, the shift walk and the response.
// Depends on skit_pkg and the assertion macro header.
`include "sorted_key_insert_table_top_assert.svh"
module skit_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	input  skit_pkg::sts_t    sts,
	output skit_pkg::cmd_t    cmd
);
	import skit_pkg::*;

	typedef enum logic [2:0] {
		IDLE,
		CHECK,
		FETCH,
		CMP,
		FINISH
	} state_t;

	state_t    state_q;
	state_t    state_d;
	res_kind_t kind_q;
	res_kind_t kind_d;
	logic      rsp_valid_q;

	always_comb begin
		cmd      = '0;
		cmd.kind = kind_q;
		state_d  = state_q;
		kind_d   = kind_q;
		case (state_q)
			IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = CHECK;
				end
			end
			CHECK: begin
				state_d = FINISH;
				if (sts.is_read) begin
					if (sts.range_err) begin
						kind_d = RES_RANGE;
					end else begin
						cmd.rd_pos = 1'b1;
						kind_d     = RES_READ;
					end
				end else if (sts.full) begin
					kind_d = RES_FULL;
				end else begin
					kind_d  = RES_INSERT;
					state_d = FETCH;
				end
			end
			FETCH: begin
				if (sts.at_zero) begin
					cmd.wr_fresh = 1'b1;
					state_d      = FINISH;
				end else begin
					cmd.rd_prev = 1'b1;
					state_d     = CMP;
				end
			end
			CMP: begin
				if (sts.ge) begin
					cmd.wr_shift = 1'b1;
					state_d      = FETCH;
				end else begin
					cmd.wr_fresh = 1'b1;
					state_d      = FINISH;
				end
			end
			FINISH: begin
				if (!rsp_valid_q || !rsp_stall) begin
					cmd.emit = 1'b1;
					state_d  = IDLE;
				end
			end
			default: begin
				state_d = IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			kind_q      <= RES_INSERT;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
			if (cmd.emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign req_stall = (state_q != IDLE);
	assign rsp_valid = rsp_valid_q;

	// A shift always has an entry above it to move down.
	`SKIT_ASSERT_NOW(a_shift_has_source, clk, arst_n, cmd.wr_shift, !sts.at_zero)
	// At most one memory access is commanded in a cycle.
	`SKIT_ASSERT_NOW(a_one_access, clk, arst_n, 1'b1,
		$onehot0({cmd.rd_pos, cmd.rd_prev, cmd.wr_shift, cmd.wr_fresh}))
	// A new response never overwrites one that is still waiting.
	`SKIT_ASSERT_NOW(a_no_overwrite, clk, arst_n, cmd.emit, !rsp_valid_q || !rsp_stall)

endmodule

// ===== rtl/core/skit_dp.sv =====
// Datapath of the sorted key insert table: entry memory, count, walk index and response register.
// Depends on skit_pkg and the assertion macro header.
`include "sorted_key_insert_table_top_assert.svh"
module skit_dp #(
	parameter int CAPACITY = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  skit_pkg::req_t req,
	input  skit_pkg::cmd_t cmd,
	output skit_pkg::sts_t sts,
	output skit_pkg::rsp_t rsp
);
	import skit_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = CW + 6;
	localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);

	entry_t        mem [CAPACITY];
	entry_t        rdata_q;
	req_t          req_q;
	rsp_t          rsp_q;
	rsp_t          rsp_d;
	logic [CW-1:0] count_q;
	logic [CW-1:0] j_q;
	logic [CW-1:0] jm1;
	logic [PW-1:0] pos_ext;
	logic [PW-1:0] count_ext;
	entry_t        fresh;
	logic          mem_wr;
	logic [AW-1:0] waddr;
	entry_t        wdata;
	logic [AW-1:0] raddr;

	assign fresh     = '{day: req_q.day, hour: req_q.hour, minute: req_q.minute,
		tag: req_q.message_tag};
	assign jm1       = j_q - 1'b1;
	assign pos_ext   = PW'(req_q.position);
	assign count_ext = PW'(count_q);

	assign sts.is_read   = (req_q.action == ACT_READ);
	assign sts.full      = (count_q >= CW'(CAPACITY));
	assign sts.range_err = (pos_ext >= count_ext) || (pos_ext >= CAP_P);
	assign sts.at_zero   = (j_q == '0);
	assign sts.ge        = key_ge(rdata_q, fresh);

	assign mem_wr = cmd.wr_shift || cmd.wr_fresh;
	assign waddr  = j_q[AW-1:0];
	assign wdata  = cmd.wr_shift ? rdata_q : fresh;
	assign raddr  = cmd.rd_pos ? pos_ext[AW-1:0] : jm1[AW-1:0];

	always_ff @(posedge clk) begin
		if (mem_wr) begin
			mem[waddr] <= wdata;
		end
		if (cmd.rd_pos || cmd.rd_prev) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.wr_fresh) begin
			count_q <= count_q + 1'b1;
		end
	end

	// The response is assembled here and loaded in one piece when the controller emits it.
	always_comb begin
		rsp_d             = '0;
		rsp_d.entry_count = 7'(count_q);
		case (cmd.kind)
			RES_FULL:  rsp_d.status = ST_FULL;
			RES_RANGE: rsp_d.status = ST_RANGE;
			RES_READ: begin
				rsp_d.status     = ST_DONE;
				rsp_d.out_day    = rdata_q.day;
				rsp_d.out_hour   = rdata_q.hour;
				rsp_d.out_minute = rdata_q.minute;
				rsp_d.out_tag    = rdata_q.tag;
			end
			default:   rsp_d.status = ST_DONE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
			j_q   <= count_q;
		end else if (cmd.wr_shift) begin
			j_q <= jm1;
		end
		if (cmd.emit) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp = rsp_q;

	// The walk starts at the current fill level.
	`SKIT_ASSERT_NEXT(a_walk_start, clk, arst_n, cmd.load, j_q == $past(count_q))
	// The new entry is only written into a table with room left.
	`SKIT_ASSERT_NOW(a_fresh_has_room, clk, arst_n, cmd.wr_fresh, !sts.full)
	// Each insert raises the count by exactly one.
	`SKIT_ASSERT_NEXT(a_count_step, clk, arst_n, cmd.wr_fresh,
		count_q == $past(count_q) + 1'b1)

endmodule

// ===== rtl/core/sorted_key_insert_table_top.sv =====
// Top level of the sorted key insert table: joins the controller and the datapath.
// Depends on skit_pkg, skit_ctrl and skit_dp.
//
//   channel   direction   handshake            payload
//   req       in          req_valid/req_stall  skit_pkg::req_t (insert or read)
//   rsp       out         rsp_valid/rsp_stall  skit_pkg::rsp_t (one per request)
//
// A read, a refused insert or an out-of-range read passes from the check state to the final
// state, whose emit raises rsp_valid. An insert walks from the last entry toward the front,
// each entry that moves down taking one registered read, then compare and write; it ends
// on a lower key or at the front, then writes the new entry and emits.
// Reset clears only the count and control state; reads stop below the count.
// req_stall is high from the accepting edge until the edge that raises rsp_valid; a response
// still waiting under rsp_stall holds the next one in the final state until it is taken.
module sorted_key_insert_table_top #(
	parameter int CAPACITY = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  skit_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output skit_pkg::rsp_t rsp
);
	import skit_pkg::*;

	// Commands flow from the controller to the datapath; status flags flow back.
	cmd_t cmd;
	sts_t sts;

	// The controller owns both handshakes and the order of memory accesses.
	skit_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds the entries, the count and the response register.
	skit_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule
